/* sv/ffa_pkg.sv */
package ffa_pkg;

	// port widths
	localparam int ADDR_W = 17;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int SIZE_W = 18;

	// defaults for the top level parameters
	localparam int ARENA_BYTES_DEF  = 65536;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ALIGN_BYTES_DEF  = 8;

	// header slots are 8 bytes apart, a split leaves at least 8 payload bytes
	localparam int SLOT_SHIFT = 3;
	localparam int MIN_SPLIT  = 8;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ARENA = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADADDR = 2'd2;

	// classified item handed from front to back
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] target;
		logic              bad;
	} cmd_t;

endpackage

/* sv/ffa_front.sv */
module ffa_front #(
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        ready,
	input  logic [ffa_pkg::FUNC_W-1:0]  func,
	input  logic [ffa_pkg::ADDR_W-1:0]  request_size,
	input  logic [ffa_pkg::ADDR_W-1:0]  block_address,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output ffa_pkg::cmd_t               cmd
);
	import ffa_pkg::*;

	localparam logic [SIZE_W-1:0] ALIGN_M = SIZE_W'(ALIGN_BYTES - 1);
	localparam logic [ADDR_W-1:0] HDR_A   = ADDR_W'(HEADER_BYTES);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic [SIZE_W-1:0] size_sum;
	logic       push;
	logic       pop;

	// classify: round the size up, form the header offset of a free
	assign size_sum   = SIZE_W'(request_size) + ALIGN_M;
	assign cls.func   = func;
	assign cls.size   = size_sum & ~ALIGN_M;
	assign cls.target = block_address - HDR_A;
	assign cls.bad    = block_address < HDR_A;

	assign ready     = count_q != 2'd2;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = valid && ready;
	assign pop       = cmd_valid && cmd_ready;

	// two-entry item queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

endmodule

/* sv/ffa_back.sv */
module ffa_back #(
	parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  ffa_pkg::cmd_t              cmd,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ffa_pkg::ADDR_W-1:0] payload_address,
	output logic [ffa_pkg::STAT_W-1:0] status
);
	import ffa_pkg::*;

	localparam int OW    = $clog2(ARENA_BYTES + 1);
	localparam int XW    = (OW > SIZE_W ? OW : SIZE_W) + 2;
	localparam int SLOTS = (ARENA_BYTES + 7) / 8;
	localparam int SW    = $clog2(SLOTS);
	localparam logic [XW-1:0] HB    = XW'(HEADER_BYTES);
	localparam logic [XW-1:0] ARENA = XW'(ARENA_BYTES);
	localparam logic [XW-1:0] SPLIT = XW'(HEADER_BYTES + MIN_SPLIT);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACHK = 4'd1;
	localparam logic [3:0] S_ADAT = 4'd2;
	localparam logic [3:0] S_AWR2 = 4'd3;
	localparam logic [3:0] S_FCHK = 4'd4;
	localparam logic [3:0] S_FDAT = 4'd5;
	localparam logic [3:0] S_CCHK = 4'd6;
	localparam logic [3:0] S_CDAT = 4'd7;
	localparam logic [3:0] S_CNXT = 4'd8;

	// header store: free flag over block size
	logic [OW:0]   mem [SLOTS];
	logic [OW:0]   rd_q;
	logic          we;
	logic          re;
	logic [SW-1:0] wa;
	logic [SW-1:0] ra;
	logic [OW:0]   wd;

	logic [3:0]        state_q;
	logic [OW-1:0]     cur_q;
	logic [OW-1:0]     frontier_q;
	logic [OW-1:0]     hs_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] target_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [STAT_W-1:0] stat_q;

	logic          rd_free;
	logic [XW-1:0] cur_x;
	logic [XW-1:0] sz_x;
	logic [XW-1:0] fr_x;
	logic [XW-1:0] hs_x;
	logic [XW-1:0] tg_x;
	logic [XW-1:0] nxt_x;
	logic [XW-1:0] cut_x;
	logic [XW-1:0] merge_x;
	logic          fits;
	logic          split;
	logic          take;

	function automatic logic [SW-1:0] slot(input logic [XW-1:0] off);
		slot = SW'(off >> SLOT_SHIFT);
	endfunction

	assign rd_free = rd_q[OW];
	assign cur_x   = XW'(cur_q);
	assign sz_x    = XW'(size_q);
	assign fr_x    = XW'(frontier_q);
	assign hs_x    = XW'(rd_q[OW-1:0]);
	assign tg_x    = XW'(target_q);
	assign nxt_x   = cur_x + HB + hs_x;
	assign cut_x   = cur_x + HB + sz_x;
	assign merge_x = XW'(hs_q) + HB + hs_x;
	assign fits    = rd_free && hs_x >= sz_x;
	assign split   = hs_x >= sz_x + SPLIT;
	assign take    = state_q == S_IDLE && cmd_valid && !out_valid_q;

	assign cmd_ready       = take;
	assign out_valid       = out_valid_q;
	assign payload_address = addr_q;
	assign status          = stat_q;

	// header store port control
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = slot(cur_x);
		ra = slot(cur_x);
		wd = {1'b0, size_q[OW-1:0]};
		unique case (state_q)
			S_IDLE: begin
				if (take && cmd.func == FUNC_ARENA) begin
					we = 1'b1;
					wa = '0;
					wd = {1'b1, OW'(ARENA - HB)};
				end
			end
			S_ACHK: begin
				if (cur_q == frontier_q) begin
					we = cut_x <= ARENA;
					wd = {1'b0, OW'(sz_x)};
				end else begin
					re = cur_x < ARENA;
				end
			end
			S_ADAT: begin
				if (fits) begin
					we = 1'b1;
					if (split) begin
						wa = slot(cut_x);
						wd = {1'b1, OW'(hs_x - sz_x - HB)};
					end else begin
						wd = {1'b0, OW'(hs_x)};
					end
				end
			end
			S_AWR2: begin
				we = 1'b1;
				wd = {1'b0, OW'(sz_x)};
			end
			S_FCHK: re = cur_q < frontier_q;
			S_FDAT: begin
				we = cur_x == tg_x;
				wd = {1'b1, OW'(hs_x)};
			end
			S_CCHK: re = cur_q < frontier_q;
			S_CDAT: begin
				re = rd_free && nxt_x < fr_x;
				ra = slot(nxt_x);
			end
			S_CNXT: begin
				we = rd_free;
				wd = {1'b1, OW'(merge_x)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	// header walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frontier_q  <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			hs_q        <= '0;
			size_q      <= '0;
			target_q    <= '0;
			addr_q      <= '0;
			stat_q      <= STAT_DONE;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						cur_q    <= '0;
						size_q   <= cmd.size;
						target_q <= cmd.target;
						addr_q   <= '0;
						stat_q   <= STAT_DONE;
						case (cmd.func)
							FUNC_ALLOC: state_q <= S_ACHK;
							FUNC_FREE: begin
								if (cmd.bad) begin
									stat_q      <= STAT_BADADDR;
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_FCHK;
								end
							end
							FUNC_ARENA: begin
								frontier_q  <= OW'(ARENA);
								out_valid_q <= 1'b1;
							end
							default: out_valid_q <= 1'b1;
						endcase
					end
				end
				S_ACHK: begin
					if (cur_q == frontier_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (cut_x > ARENA) begin
							stat_q <= STAT_NOSPACE;
						end else begin
							frontier_q <= OW'(cut_x);
							addr_q     <= ADDR_W'(cur_x + HB);
						end
					end else if (cur_x >= ARENA) begin
						stat_q      <= STAT_NOSPACE;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_ADAT;
					end
				end
				S_ADAT: begin
					if (fits) begin
						addr_q <= ADDR_W'(cur_x + HB);
						if (split) begin
							state_q <= S_AWR2;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						cur_q   <= OW'(nxt_x);
						state_q <= S_ACHK;
					end
				end
				S_AWR2: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FCHK: begin
					if (cur_q < frontier_q) begin
						state_q <= S_FDAT;
					end else begin
						stat_q      <= STAT_BADADDR;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_FDAT: begin
					if (cur_x == tg_x) begin
						cur_q   <= '0;
						state_q <= S_CCHK;
					end else if (cur_x > tg_x) begin
						stat_q      <= STAT_BADADDR;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						cur_q   <= OW'(nxt_x);
						state_q <= S_FCHK;
					end
				end
				S_CCHK: begin
					if (cur_q < frontier_q) begin
						state_q <= S_CDAT;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CDAT: begin
					hs_q <= OW'(hs_x);
					if (rd_free && nxt_x < fr_x) begin
						state_q <= S_CNXT;
					end else begin
						cur_q   <= OW'(nxt_x);
						state_q <= S_CCHK;
					end
				end
				S_CNXT: begin
					// absorb the next block when free, else step onto it
					if (!rd_free) cur_q <= OW'(cur_x + HB + XW'(hs_q));
					state_q <= S_CCHK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/first_fit_arena_allocator.sv */
// first-fit arena allocator with block split and forward merge
// input channel: valid/ready with func, request_size and block_address;
// func selects allocate, free block or arena reset (code 3 answers done)
// output channel: valid/ready with payload_address and status, one item
// out for every item in, in order
// an allocate walks the block headers from offset 0, a check and a data
// state a header, and appends at the frontier when no free block fits
// a free walks to the block (a check and a data state a header), then runs
// one merge pass over the whole chain, through check, data and next states
// arena reset and code 3 raise their result in the cycle after the accept,
// so with an idle walker an item passes only the queue and result register
// latency is set by the header count walked through the single-port
// header store; one item is worked on at a time
// a two-entry queue keeps taking items while the walker is busy or the
// result register waits on a stalled receiver
// after reset the arena is empty and the frontier sits at offset 0;
// no clearing pass is needed
module first_fit_arena_allocator #(
	parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ffa_pkg::FUNC_W-1:0] func,
	input  logic [ffa_pkg::ADDR_W-1:0] request_size,
	input  logic [ffa_pkg::ADDR_W-1:0] block_address,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ffa_pkg::ADDR_W-1:0] payload_address,
	output logic [ffa_pkg::STAT_W-1:0] status
);
	import ffa_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	// front: accept, classify and queue
	ffa_front #(
		.HEADER_BYTES(HEADER_BYTES),
		.ALIGN_BYTES (ALIGN_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (in_valid),
		.ready        (in_ready),
		.func         (func),
		.request_size (request_size),
		.block_address(block_address),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	// back: header walk and result register
	ffa_back #(
		.ARENA_BYTES (ARENA_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_address(payload_address),
		.status         (status)
	);

endmodule
